// ===== rtl/interval_set_insert_coalesce_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef INTERVAL_SET_INSERT_COALESCE_DEFINES_SVH
`define INTERVAL_SET_INSERT_COALESCE_DEFINES_SVH

// Condition must hold on every clock edge out of reset.
`define ISIC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ISIC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ISIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/isic_pkg.sv =====
`timescale 1ns / 1ps

package isic_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VAL_W   = 16;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_BUILD,
    S_LIST
  } isic_state_t;

  // Overlap or adjacency test, done at one extra bit so the top value never wraps.
  function automatic logic meets(input logic [VAL_W-1:0] alo, input logic [VAL_W-1:0] ahi,
                                 input logic [VAL_W-1:0] blo, input logic [VAL_W-1:0] bhi);
    logic [VAL_W:0] ahi1;
    logic [VAL_W:0] bhi1;
    ahi1 = {1'b0, ahi} + {{VAL_W{1'b0}}, 1'b1};
    bhi1 = {1'b0, bhi} + {{VAL_W{1'b0}}, 1'b1};
    return (ahi1 >= {1'b0, blo}) && (bhi1 >= {1'b0, alo});
  endfunction

endpackage

// ===== rtl/interval_set_insert_coalesce.sv =====
// Interval table insert with coalescing: one range in, whole sorted table out.
// Each accepted range is scanned against the table, the table is rebuilt into the spare bank
// and then listed; a full table with no merge skips the rebuild, a refused range both passes.
// Listing gives one result a cycle; the next range is taken only once the listing has ended
// and busy is low.
// Synchronous active-high reset empties the table; results cannot be stalled.
`timescale 1ns / 1ps

module interval_set_insert_coalesce
  import isic_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [VAL_W-1:0] range_low,
  input  logic [VAL_W-1:0] range_high,
  output logic             result_valid,
  output logic [VAL_W-1:0] entry_lo,
  output logic [VAL_W-1:0] entry_hi,
  output logic             is_last,
  output logic [1:0]       status
);

`include "interval_set_insert_coalesce_defines.svh"

  // Two banks of entries: the active bank is read, the rebuilt table goes
  // into the other one, and the banks swap when the rebuild is done.
  logic [VAL_W-1:0] tab_lo [2][DEPTH];
  logic [VAL_W-1:0] tab_hi [2][DEPTH];

  isic_state_t      state, state_next;
  logic             bank_sel, bank_sel_next;
  logic [CNT_W-1:0] count, count_next;   // entries in the active bank
  logic [CNT_W-1:0] idx, idx_next;       // read position
  logic [CNT_W-1:0] wpos, wpos_next;     // write position in the spare bank
  logic [VAL_W-1:0] in_lo, in_lo_next;   // range as it arrived
  logic [VAL_W-1:0] in_hi, in_hi_next;
  logic [VAL_W-1:0] mlo, mlo_next;       // merged range so far
  logic [VAL_W-1:0] mhi, mhi_next;
  logic             merged, merged_next;
  logic             placed, placed_next;
  logic [1:0]       stat, stat_next;

  logic             result_valid_next;
  logic [VAL_W-1:0] entry_lo_next, entry_hi_next;
  logic             is_last_next;
  logic [1:0]       status_next;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [VAL_W-1:0] wr_lo, wr_hi;

  logic [VAL_W-1:0] rd_lo, rd_hi;
  logic             hit;

  // Shared unit: one table read and one overlap/adjacency compare a cycle.
  assign rd_lo = tab_lo[bank_sel][idx[IDX_W-1:0]];
  assign rd_hi = tab_hi[bank_sel][idx[IDX_W-1:0]];
  assign hit   = meets(in_lo, in_hi, rd_lo, rd_hi);

  assign busy  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bank_sel     <= 1'b0;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      bank_sel     <= bank_sel_next;
      count        <= count_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    wpos     <= wpos_next;
    in_lo    <= in_lo_next;
    in_hi    <= in_hi_next;
    mlo      <= mlo_next;
    mhi      <= mhi_next;
    merged   <= merged_next;
    placed   <= placed_next;
    stat     <= stat_next;
    entry_lo <= entry_lo_next;
    entry_hi <= entry_hi_next;
    is_last  <= is_last_next;
    status   <= status_next;
    if (wr_en) begin
      tab_lo[~bank_sel][wr_idx] <= wr_lo;
      tab_hi[~bank_sel][wr_idx] <= wr_hi;
    end
  end

  always_comb begin
    state_next        = state;
    bank_sel_next     = bank_sel;
    count_next        = count;
    idx_next          = idx;
    wpos_next         = wpos;
    in_lo_next        = in_lo;
    in_hi_next        = in_hi;
    mlo_next          = mlo;
    mhi_next          = mhi;
    merged_next       = merged;
    placed_next       = placed;
    stat_next         = stat;
    result_valid_next = 1'b0;
    entry_lo_next     = entry_lo;
    entry_hi_next     = entry_hi;
    is_last_next      = is_last;
    status_next       = status;
    wr_en             = 1'b0;
    wr_idx            = wpos[IDX_W-1:0];
    wr_lo             = mlo;
    wr_hi             = mhi;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          in_lo_next  = range_low;
          in_hi_next  = range_high;
          mlo_next    = range_low;
          mhi_next    = range_high;
          merged_next = 1'b0;
          idx_next    = '0;
          if (range_low > range_high) begin
            // refused: table untouched, just list it
            stat_next  = ST_INVALID;
            state_next = S_LIST;
          end else begin
            stat_next  = ST_OK;
            state_next = S_SCAN;
          end
        end
      end

      // Pass one: widen the merged range over every entry the new range meets.
      S_SCAN: begin
        if (idx == count) begin
          idx_next    = '0;
          wpos_next   = '0;
          placed_next = 1'b0;
          if (!merged && (count == CNT_W'(DEPTH))) begin
            stat_next  = ST_FULL;
            state_next = S_LIST;
          end else begin
            state_next = S_BUILD;
          end
        end else begin
          if (hit) begin
            merged_next = 1'b1;
            if (rd_lo < mlo) mlo_next = rd_lo;
            if (rd_hi > mhi) mhi_next = rd_hi;
          end
          idx_next = idx + 1'b1;
        end
      end

      // Pass two: copy untouched entries across, slotting the merged range in ahead of
      // the first entry above it, or at the end if none is (a write of its own, no read step).
      S_BUILD: begin
        if (idx == count) begin
          if (!placed) begin
            wr_en     = 1'b1;
            wpos_next = wpos + 1'b1;
            count_next = wpos + 1'b1;
          end else begin
            count_next = wpos;
          end
          bank_sel_next = ~bank_sel;
          idx_next      = '0;
          state_next    = S_LIST;
        end else if (hit) begin
          idx_next = idx + 1'b1;
        end else if (!placed && (rd_lo > mhi)) begin
          wr_en       = 1'b1;
          wpos_next   = wpos + 1'b1;
          placed_next = 1'b1;
        end else begin
          wr_en     = 1'b1;
          wr_lo     = rd_lo;
          wr_hi     = rd_hi;
          wpos_next = wpos + 1'b1;
          idx_next  = idx + 1'b1;
        end
      end

      // One result a cycle; an empty table gives a single zero entry.
      S_LIST: begin
        result_valid_next = 1'b1;
        status_next       = stat;
        if (count == '0) begin
          entry_lo_next = '0;
          entry_hi_next = '0;
          is_last_next  = 1'b1;
          state_next    = S_IDLE;
        end else begin
          entry_lo_next = rd_lo;
          entry_hi_next = rd_hi;
          if (CNT_W'(idx + 1'b1) == count) begin
            is_last_next = 1'b1;
            state_next   = S_IDLE;
          end else begin
            is_last_next = 1'b0;
            idx_next     = idx + 1'b1;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ISIC_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH), "entry count above table depth")
  `ISIC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
  `ISIC_ASSERT_IMPL(a_mid_list_busy, result_valid && !is_last, busy, "listing stopped early")
  `ISIC_ASSERT_NEXT(a_gap_after_last, result_valid && is_last, !result_valid,
                    "result after end of listing")

endmodule

// ===== tb/isic_listing_checker.sv =====
`timescale 1ns / 1ps

module isic_listing_checker
  import isic_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [VAL_W-1:0] range_low,
  input  logic [VAL_W-1:0] range_high,
  input  logic             result_valid,
  input  logic [VAL_W-1:0] entry_lo,
  input  logic [VAL_W-1:0] entry_hi,
  input  logic             is_last,
  input  logic [1:0]       status,
  output int               fail_count,
  output int               pending
);

  typedef struct {
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic             last;
    logic [1:0]       status;
  } listing_word_t;

  // Shadow of the range table
  logic [VAL_W-1:0] span_lo [DEPTH];
  logic [VAL_W-1:0] span_hi [DEPTH];
  int               span_count;
  listing_word_t    listing_q [$];

  // Overlap or adjacency at one extra bit, so 65535 + 1 does not wrap
  function automatic bit spans_join(input logic [VAL_W-1:0] lo_a, input logic [VAL_W-1:0] hi_a,
                                    input logic [VAL_W-1:0] lo_b, input logic [VAL_W-1:0] hi_b);
    return ({1'b0, hi_a} + 1'b1 >= {1'b0, lo_b}) && ({1'b0, hi_b} + 1'b1 >= {1'b0, lo_a});
  endfunction

  // Applies one range to the shadow table and queues the listing it causes
  function automatic void insert_and_list(input logic [VAL_W-1:0] lo,
                                          input logic [VAL_W-1:0] hi);
    logic [VAL_W-1:0] new_lo [DEPTH];
    logic [VAL_W-1:0] new_hi [DEPTH];
    logic [VAL_W-1:0] m_lo;
    logic [VAL_W-1:0] m_hi;
    logic [1:0]       st;
    int               k;
    bit               hit;
    bit               placed;
    listing_word_t    w;
    st     = ST_OK;
    m_lo   = lo;
    m_hi   = hi;
    hit    = 1'b0;
    placed = 1'b0;
    k      = 0;
    if (lo > hi) begin
      st = ST_INVALID;
    end else begin
      for (int i = 0; i < span_count; i++) begin
        if (spans_join(lo, hi, span_lo[i], span_hi[i])) begin
          hit = 1'b1;
          if (span_lo[i] < m_lo) m_lo = span_lo[i];
          if (span_hi[i] > m_hi) m_hi = span_hi[i];
        end
      end
      if (!hit && span_count >= DEPTH) begin
        st = ST_FULL;
      end else begin
        for (int i = 0; i < span_count; i++) begin
          if (spans_join(lo, hi, span_lo[i], span_hi[i])) continue;
          if (!placed && span_lo[i] > m_hi) begin
            if (k < DEPTH) begin
              new_lo[k] = m_lo;
              new_hi[k] = m_hi;
              k++;
            end
            placed = 1'b1;
          end
          if (k < DEPTH) begin
            new_lo[k] = span_lo[i];
            new_hi[k] = span_hi[i];
            k++;
          end
        end
        if (!placed && k < DEPTH) begin
          new_lo[k] = m_lo;
          new_hi[k] = m_hi;
          k++;
        end
        for (int i = 0; i < k; i++) begin
          span_lo[i] = new_lo[i];
          span_hi[i] = new_hi[i];
        end
        span_count = k;
      end
    end
    w.status = st;
    if (span_count == 0) begin
      w.lo   = '0;
      w.hi   = '0;
      w.last = 1'b1;
      listing_q.push_back(w);
    end else begin
      for (int i = 0; i < span_count; i++) begin
        w.lo   = span_lo[i];
        w.hi   = span_hi[i];
        w.last = (i == span_count - 1);
        listing_q.push_back(w);
      end
    end
  endfunction

  always @(posedge clk) begin : track
    listing_word_t want;
    int            errs;
    errs = 0;
    if (rst) begin
      listing_q.delete();
      span_count = 0;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      // a result word is compared before any new range is applied
      if (result_valid) begin
        if (listing_q.size() == 0) begin
          $error("unexpected listing word: entry_lo %0d entry_hi %0d", entry_lo, entry_hi);
          errs++;
        end else begin
          want = listing_q.pop_front();
          if (entry_lo !== want.lo) begin
            $error("entry_lo: expected %0d, actual %0d", want.lo, entry_lo);
            errs++;
          end
          if (entry_hi !== want.hi) begin
            $error("entry_hi: expected %0d, actual %0d", want.hi, entry_hi);
            errs++;
          end
          if (is_last !== want.last) begin
            $error("is_last: expected %0d, actual %0d", want.last, is_last);
            errs++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errs++;
          end
        end
      end
      if (start && !busy) insert_and_list(range_low, range_high);
      fail_count <= fail_count + errs;
      pending    <= listing_q.size();
    end
  end

endmodule

// ===== tb/interval_set_insert_coalesce_tb.sv =====
`timescale 1ns / 1ps

module interval_set_insert_coalesce_tb;
  import isic_pkg::*;

  localparam int RANDOM_ITEMS = 260;
  // no word moved for this many cycles means the block is hung; the limit
  // sits well above a full scan/build and the longest sender pause
  localparam int STALL_LIMIT  = 2000;
  // idle tail after the last expected word
  localparam int DRAIN_CYCLES = 100;
  // random items in this window go out back to back
  localparam int BURST_FIRST  = 100;
  localparam int BURST_LAST   = 179;

  logic             clk        = 1'b0;
  logic             rst        = 1'b1;
  logic             start      = 1'b0;
  logic [VAL_W-1:0] range_low  = '0;
  logic [VAL_W-1:0] range_high = '0;
  logic             busy;
  logic             result_valid;
  logic [VAL_W-1:0] entry_lo;
  logic [VAL_W-1:0] entry_hi;
  logic             is_last;
  logic [1:0]       status;
  int               fail_count;
  int               pending;
  int               quiet_cycles;

  always #5 clk = ~clk;

  interval_set_insert_coalesce dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .range_low    (range_low),
    .range_high   (range_high),
    .result_valid (result_valid),
    .entry_lo     (entry_lo),
    .entry_hi     (entry_hi),
    .is_last      (is_last),
    .status       (status)
  );

  // Predicts every listing and checks it word by word
  isic_listing_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .range_low    (range_low),
    .range_high   (range_high),
    .result_valid (result_valid),
    .entry_lo     (entry_lo),
    .entry_hi     (entry_hi),
    .is_last      (is_last),
    .status       (status),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Watchdog: restarts whenever a word is accepted on either side
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one range and returns on the edge that takes it. busy is looked
  // at on the falling edge, where it already holds its pre-edge value, so
  // the accept decision never races the block's own update.
  task automatic send_range(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi,
                            input bit may_pause);
    int pause;
    if (may_pause && $urandom_range(99, 0) < 35) begin
      // mostly short gaps; the odd long one lands deep in scan/build/listing
      pause = ($urandom_range(99, 0) < 80) ? $urandom_range(6, 1) : $urandom_range(60, 7);
      start <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    start      <= 1'b1;
    range_low  <= lo;
    range_high <= hi;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Random range. Most land on a coarse grid inside a few clusters so that
  // overlaps, touching ends and a full table all turn up often; the rest are
  // refusals, wide sweeps that collapse the table, ranges pressed against
  // the top value, and fully random pairs so every input bit toggles.
  function automatic void pick_range(output logic [VAL_W-1:0] lo,
                                     output logic [VAL_W-1:0] hi);
    int roll;
    int a;
    int b;
    roll = $urandom_range(99, 0);
    if (roll < 7) begin
      a = $urandom_range(65535, 1);
      b = $urandom_range(a - 1, 0);
    end else if (roll < 12) begin
      a = $urandom_range(65535, 0);
      b = $urandom_range(65535, a);
    end else if (roll < 22) begin
      a = $urandom_range(65535, 0);
      b = $urandom_range(65535, 0);
      if (a > b) begin
        roll = a;
        a    = b;
        b    = roll;
      end
    end else if (roll < 26) begin
      a = $urandom_range(65535, 65520);
      b = $urandom_range(65535, a);
    end else if (roll < 36) begin
      a = $urandom_range(7, 0) * 8192 + $urandom_range(31, 0) * 4;
      b = a + $urandom_range(200, 0);
    end else begin
      a = $urandom_range(7, 0) * 8192 + $urandom_range(31, 0) * 4;
      b = a + $urandom_range(3, 0);
    end
    lo = a[VAL_W-1:0];
    hi = b[VAL_W-1:0];
  endfunction

  initial begin
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part; the table carries over from word to word.
    send_range(16'd5, 16'd3, 1'b1);           // refused on an empty table
    send_range(16'd0, 16'd0, 1'b1);           // first entry, bottom value
    send_range(16'd65535, 16'd65535, 1'b1);   // top value
    send_range(16'd65533, 16'd65533, 1'b1);   // one gap below the top
    send_range(16'd65534, 16'd65534, 1'b1);   // touches both neighbours
    send_range(16'd2, 16'd2, 1'b1);
    send_range(16'd1, 16'd1, 1'b1);           // bridges 0 and 2
    // fill to DEPTH; each lands in front of the top entry
    for (int i = 1; i <= DEPTH - 2; i++)
      send_range(VAL_W'(i * 100), VAL_W'(i * 100 + 10), 1'b1);
    send_range(16'd5000, 16'd5000, 1'b1);     // full table, nothing to merge
    send_range(16'd1411, 16'd1420, 1'b1);     // full table, merge by touching
    send_range(16'd65535, 16'd0, 1'b1);       // refused on a full table
    send_range(16'd0, 16'd65535, 1'b1);       // swallows the whole table

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick_range(lo, hi);
      send_range(lo, hi, !(n >= BURST_FIRST && n <= BURST_LAST));
    end
    start <= 1'b0;

    // let the checker see the last accept before looking at what is owed
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/isic_pkg.sv
rtl/interval_set_insert_coalesce.sv
tb/isic_listing_checker.sv
tb/interval_set_insert_coalesce_tb.sv
